FILE: rtl/scl_pkg.sv
// Shared types, register indexes and width helpers for the screen line clipper.
// No dependencies.
`default_nettype none
package scl_pkg;

  localparam int COORD_FRAC_BITS_DEF = 8;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int DEN_W   = 25;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd360;

  // signed width of a boundary distance for a given coordinate fraction
  function automatic int scl_num_w(input int c);
    return ((c + 13 > 24) ? c + 13 : 24) + 3;
  endfunction

  typedef struct packed {
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] end_x;
    logic signed [23:0] end_y;
    logic [15:0]        start_depth;
    logic [15:0]        end_depth;
    logic [7:0]         line_thickness;
  } scl_in_t;

  typedef struct packed {
    logic               visible;
    logic signed [23:0] clip_start_x;
    logic signed [23:0] clip_start_y;
    logic signed [23:0] clip_end_x;
    logic signed [23:0] clip_end_y;
    logic [15:0]        clip_start_depth;
    logic [15:0]        clip_end_depth;
    logic [16:0]        t_entry;
    logic [16:0]        t_exit;
  } scl_out_t;

  // per-segment data that rides along the divider pipeline
  typedef struct packed {
    logic               valid;
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [15:0]        da;
    logic signed [16:0] dd;
    logic               zrej;
    logic [3:0]         skip;
    logic [3:0]         enter;
    logic [3:0]         neg;
    logic [3:0]         ovf;
  } scl_side_t;

endpackage
`default_nettype wire

FILE: rtl/scl_setup.sv
// Front end: margin, direction and boundary distances, magnitudes and flags.
// Depends on scl_pkg.
`default_nettype none
module scl_setup import scl_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire scl_in_t              in_data,
  input  wire logic [CFG_W-1:0]     screen_width,
  input  wire logic [CFG_W-1:0]     screen_height,
  output scl_side_t                 side,
  output logic [scl_num_w(COORD_FRAC_BITS)-1:0] num [4],
  output logic [DEN_W-1:0]          den [4]
);

  localparam int C  = COORD_FRAC_BITS;
  localparam int QW = scl_num_w(COORD_FRAC_BITS);
  localparam int MW = C + 9;

  // stage 1: input word and margin
  logic          v1;
  scl_in_t       it1;
  logic [MW-1:0] margin1;
  logic [MW-1:0] m_raw, m_min, m_sel;

  always_comb begin
    m_raw = ((MW'({in_data.line_thickness, 1'b0}) + MW'(in_data.line_thickness)) << (C - 2))
            + (MW'(1) << C);
    m_min = MW'(2) << C;
    m_sel = (m_raw < m_min) ? m_min : m_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      it1     <= in_data;
      margin1 <= m_sel;
    end
  end

  // stage 2: direction and signed distances to the four boundaries
  logic                  v2;
  logic signed [23:0]    sx2, sy2;
  logic signed [24:0]    dx2, dy2;
  logic [15:0]           da2;
  logic signed [16:0]    dd2;
  logic signed [QW-1:0]  q2 [4];
  logic signed [QW-1:0]  m_fx, w_fx, h_fx, sx_fx, sy_fx;

  always_comb begin
    m_fx  = QW'({1'b0, margin1});
    w_fx  = QW'({1'b0, screen_width}) << C;
    h_fx  = QW'({1'b0, screen_height}) << C;
    sx_fx = QW'(it1.start_x);
    sy_fx = QW'(it1.start_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      sx2   <= it1.start_x;
      sy2   <= it1.start_y;
      dx2   <= 25'(it1.end_x) - 25'(it1.start_x);
      dy2   <= 25'(it1.end_y) - 25'(it1.start_y);
      da2   <= it1.start_depth;
      dd2   <= 17'({1'b0, it1.end_depth}) - 17'({1'b0, it1.start_depth});
      q2[0] <= sx_fx + m_fx;
      q2[1] <= w_fx + m_fx - sx_fx;
      q2[2] <= sy_fx + m_fx;
      q2[3] <= h_fx + m_fx - sy_fx;
    end
  end

  // stage 3: magnitudes, signs and quotient overflow
  logic signed [24:0] p3 [4];
  logic [QW-1:0]      qmag [4];
  logic [DEN_W-1:0]   pmag [4];
  scl_side_t          side_next;

  always_comb begin
    p3[0] = -dx2;
    p3[1] = dx2;
    p3[2] = -dy2;
    p3[3] = dy2;
    side_next.valid = v2;
    side_next.sx    = sx2;
    side_next.sy    = sy2;
    side_next.dx    = dx2;
    side_next.dy    = dy2;
    side_next.da    = da2;
    side_next.dd    = dd2;
    side_next.zrej  = 1'b0;
    for (int b = 0; b < 4; b++) begin
      qmag[b] = q2[b][QW-1] ? QW'(-q2[b]) : QW'(q2[b]);
      pmag[b] = p3[b][24] ? DEN_W'(-p3[b]) : DEN_W'(p3[b]);
      side_next.skip[b]  = (p3[b] == '0);
      side_next.enter[b] = p3[b][24];
      side_next.neg[b]   = p3[b][24] ^ q2[b][QW-1];
      // quotient would need more than PARAM_FRAC_BITS+2 bits
      side_next.ovf[b]   = ({1'b0, qmag[b]} >= ((QW + 1)'(pmag[b]) << 2));
      side_next.zrej     = side_next.zrej | (side_next.skip[b] & q2[b][QW-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side.valid <= side_next.valid;
    end
    if (en) begin
      side.sx    <= side_next.sx;
      side.sy    <= side_next.sy;
      side.dx    <= side_next.dx;
      side.dy    <= side_next.dy;
      side.da    <= side_next.da;
      side.dd    <= side_next.dd;
      side.zrej  <= side_next.zrej;
      side.skip  <= side_next.skip;
      side.enter <= side_next.enter;
      side.neg   <= side_next.neg;
      side.ovf   <= side_next.ovf;
      for (int b = 0; b < 4; b++) begin
        num[b] <= qmag[b];
        den[b] <= pmag[b];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/scl_div.sv
// Pipelined restoring divider, one quotient bit per stage: (num << P) / den.
// Depends on scl_pkg. Valid travels outside in the side line.
`default_nettype none
module scl_div import scl_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic [scl_num_w(COORD_FRAC_BITS)-1:0] num,
  input  wire logic [DEN_W-1:0]                     den,
  output logic [PARAM_FRAC_BITS+1:0]                quo
);

  localparam int P  = PARAM_FRAC_BITS;
  localparam int L  = P + 2;

  logic [DEN_W-1:0] rem_r  [L];
  logic [L-1:0]     bits_r [L];
  logic [DEN_W-1:0] den_r  [L];
  logic [L-1:0]     quo_r  [L];

  logic [DEN_W-1:0] rem_i  [L];
  logic [L-1:0]     bits_i [L];
  logic [DEN_W-1:0] den_i  [L];
  logic [L-1:0]     quo_i  [L];
  logic [DEN_W:0]   tmp    [L];
  logic             ge     [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      if (i == 0) begin
        // top part of the numerator is below den when there is no overflow
        rem_i[i]  = DEN_W'(num >> 2);
        bits_i[i] = {num[1:0], {P{1'b0}}};
        den_i[i]  = den;
        quo_i[i]  = '0;
      end else begin
        rem_i[i]  = rem_r[i-1];
        bits_i[i] = bits_r[i-1];
        den_i[i]  = den_r[i-1];
        quo_i[i]  = quo_r[i-1];
      end
      tmp[i] = {rem_i[i], bits_i[i][L-1]};
      ge[i]  = (tmp[i] >= {1'b0, den_i[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        rem_r[i]  <= ge[i] ? DEN_W'(tmp[i] - {1'b0, den_i[i]}) : DEN_W'(tmp[i]);
        bits_r[i] <= bits_i[i] << 1;
        den_r[i]  <= den_i[i];
        quo_r[i]  <= {quo_i[i][L-2:0], ge[i]};
      end
    end
  end

  assign quo = quo_r[L-1];

endmodule
`default_nettype wire

FILE: rtl/scl_finish.sv
// Back end: clamp boundary parameters, intersect, interpolate, form the result.
// Depends on scl_pkg.
`default_nettype none
module scl_finish import scl_pkg::*; #(
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire scl_side_t                  side,
  input  wire logic [PARAM_FRAC_BITS+1:0] quo [4],
  output logic                            out_valid,
  output scl_out_t                        out_data
);

  localparam int P   = PARAM_FRAC_BITS;
  localparam int L   = P + 2;
  localparam int RW  = P + 3;
  localparam int PW  = 25 + RW;
  localparam int SHR = (P >= 16) ? P - 16 : 0;
  localparam int SHL = (P >= 16) ? 0 : 16 - P;
  localparam logic [L-1:0]           LIM = L'((1 << P) + 1);
  localparam logic signed [RW-1:0]   T_ONE = RW'(1 << P);
  localparam logic signed [PW-1:0]   RND = PW'((1 << P) - 1);

  function automatic logic signed [PW-1:0] trunc_p(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] s;
    s = v[PW-1] ? v + RND : v;
    return s >>> P;
  endfunction

  function automatic logic [16:0] to_q16(input logic signed [RW-1:0] t);
    logic [P+16:0] w;
    w = (P + 17)'(t[P:0]);
    w = (w >> SHR) << SHL;
    return w[16:0];
  endfunction

  // stage 0: clamp each parameter to the range the intersection can see
  scl_side_t          side0;
  logic signed [RW-1:0] r0 [4];
  logic [L-1:0]       mag [4];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      mag[b] = side.ovf[b] ? LIM : ((quo[b] > LIM) ? LIM : quo[b]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side0.valid <= 1'b0;
    end else if (en) begin
      side0.valid <= side.valid;
    end
    if (en) begin
      side0.sx    <= side.sx;
      side0.sy    <= side.sy;
      side0.dx    <= side.dx;
      side0.dy    <= side.dy;
      side0.da    <= side.da;
      side0.dd    <= side.dd;
      side0.zrej  <= side.zrej;
      side0.skip  <= side.skip;
      side0.enter <= side.enter;
      side0.neg   <= side.neg;
      side0.ovf   <= side.ovf;
      for (int b = 0; b < 4; b++) begin
        r0[b] <= (side.neg[b] && mag[b] != '0) ? '1 : RW'(mag[b]);
      end
    end
  end

  // stage 1: entry is the latest entering boundary, exit the earliest leaving one
  logic                 v1, ok1;
  logic signed [23:0]   sx1, sy1;
  logic signed [24:0]   dx1, dy1, dd1;
  logic [15:0]          da1;
  logic signed [RW-1:0] te1, tx1, te_c, tx_c;

  always_comb begin
    te_c = '0;
    tx_c = T_ONE;
    for (int b = 0; b < 4; b++) begin
      if (!side0.skip[b]) begin
        if (side0.enter[b]) begin
          if (r0[b] > te_c) te_c = r0[b];
        end else begin
          if (r0[b] < tx_c) tx_c = r0[b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= side0.valid;
    end
    if (en) begin
      ok1 <= !side0.zrej && !(tx_c < te_c);
      te1 <= te_c;
      tx1 <= tx_c;
      sx1 <= side0.sx;
      sy1 <= side0.sy;
      dx1 <= side0.dx;
      dy1 <= side0.dy;
      dd1 <= 25'(side0.dd);
      da1 <= side0.da;
    end
  end

  // stage 2: products
  logic                 v2, ok2;
  logic signed [23:0]   sx2, sy2;
  logic [15:0]          da2;
  logic signed [RW-1:0] te2, tx2;
  logic signed [PW-1:0] pxa, pya, pxb, pyb, pda, pdb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      ok2 <= ok1;
      te2 <= te1;
      tx2 <= tx1;
      sx2 <= sx1;
      sy2 <= sy1;
      da2 <= da1;
      pxa <= dx1 * te1;
      pya <= dy1 * te1;
      pxb <= dx1 * tx1;
      pyb <= dy1 * tx1;
      pda <= dd1 * te1;
      pdb <= dd1 * tx1;
    end
  end

  // stage 3: scale toward zero and add to the start point
  logic               v3, ok3;
  logic signed [23:0] ax3, ay3, bx3, by3;
  logic [15:0]        dpa3, dpb3;
  logic [16:0]        te3, tx3;
  logic signed [PW-1:0] ax_w, ay_w, bx_w, by_w;
  logic [PW-1:0]        dpa_w, dpb_w;

  always_comb begin
    ax_w  = trunc_p(pxa) + PW'(sx2);
    ay_w  = trunc_p(pya) + PW'(sy2);
    bx_w  = trunc_p(pxb) + PW'(sx2);
    by_w  = trunc_p(pyb) + PW'(sy2);
    dpa_w = trunc_p(pda) + PW'({1'b0, da2});
    dpb_w = trunc_p(pdb) + PW'({1'b0, da2});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      ok3  <= ok2;
      ax3  <= ax_w[23:0];
      ay3  <= ay_w[23:0];
      bx3  <= bx_w[23:0];
      by3  <= by_w[23:0];
      dpa3 <= dpa_w[15:0];
      dpb3 <= dpb_w[15:0];
      te3  <= to_q16(te2);
      tx3  <= to_q16(tx2);
    end
  end

  // stage 4: drop degenerate results, zero every field of a rejected word
  logic vis;
  assign vis = ok3 && !(ax3 == bx3 && ay3 == by3);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
    if (en) begin
      out_data.visible          <= vis;
      out_data.clip_start_x     <= vis ? ax3 : '0;
      out_data.clip_start_y     <= vis ? ay3 : '0;
      out_data.clip_end_x       <= vis ? bx3 : '0;
      out_data.clip_end_y       <= vis ? by3 : '0;
      out_data.clip_start_depth <= vis ? dpa3 : '0;
      out_data.clip_end_depth   <= vis ? dpb3 : '0;
      out_data.t_entry          <= vis ? te3 : '0;
      out_data.t_exit           <= vis ? tx3 : '0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/screen_line_clipper.sv
// Screen line clipper: clips one segment per word against the screen rectangle
// widened by a thickness-dependent margin and returns the visible part.
//
// Input channel in_valid/in_stall/in_data carries one segment word; output
// channel out_valid/out_stall/out_data carries one result word per segment,
// in order. A word moves at a clock edge with valid high and stall low.
// Throughput is one segment per cycle while out_stall lets results leave. The
// pipeline has three setup stages, PARAM_FRAC_BITS + 2 divider stages that
// resolve one quotient bit each, and five stages for clamp, intersection,
// multiply, interpolation and the output register.
// When out_stall is high while a result waits, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// The cfg port writes screen_width (index 0) or screen_height (index 1) at any
// edge with cfg_write high; other indexes are ignored. Write only while idle.
// Synchronous reset empties the pipeline and restores 640 by 360.
`default_nettype none
module screen_line_clipper import scl_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire scl_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output scl_out_t                  out_data,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int QW = scl_num_w(COORD_FRAC_BITS);
  localparam int L  = PARAM_FRAC_BITS + 2;

  logic [CFG_W-1:0] screen_width, screen_height;
  logic             en;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold every stage while the output word waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  scl_side_t        side_s;
  logic [QW-1:0]    num [4];
  logic [DEN_W-1:0] den [4];
  logic [L-1:0]     quo [4];

  scl_setup #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_setup (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .side          (side_s),
    .num           (num),
    .den           (den)
  );

  for (genvar b = 0; b < 4; b++) begin : g_div
    scl_div #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (num[b]),
      .den (den[b]),
      .quo (quo[b])
    );
  end

  // side line matched to the divider depth
  scl_side_t side_line [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) side_line[i].valid <= 1'b0;
    end else if (en) begin
      side_line[0].valid <= side_s.valid;
      for (int i = 1; i < L; i++) side_line[i].valid <= side_line[i-1].valid;
    end
    if (en) begin
      side_line[0].sx    <= side_s.sx;
      side_line[0].sy    <= side_s.sy;
      side_line[0].dx    <= side_s.dx;
      side_line[0].dy    <= side_s.dy;
      side_line[0].da    <= side_s.da;
      side_line[0].dd    <= side_s.dd;
      side_line[0].zrej  <= side_s.zrej;
      side_line[0].skip  <= side_s.skip;
      side_line[0].enter <= side_s.enter;
      side_line[0].neg   <= side_s.neg;
      side_line[0].ovf   <= side_s.ovf;
      for (int i = 1; i < L; i++) begin
        side_line[i].sx    <= side_line[i-1].sx;
        side_line[i].sy    <= side_line[i-1].sy;
        side_line[i].dx    <= side_line[i-1].dx;
        side_line[i].dy    <= side_line[i-1].dy;
        side_line[i].da    <= side_line[i-1].da;
        side_line[i].dd    <= side_line[i-1].dd;
        side_line[i].zrej  <= side_line[i-1].zrej;
        side_line[i].skip  <= side_line[i-1].skip;
        side_line[i].enter <= side_line[i-1].enter;
        side_line[i].neg   <= side_line[i-1].neg;
        side_line[i].ovf   <= side_line[i-1].ovf;
      end
    end
  end

  scl_finish #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .side      (side_line[L-1]),
    .quo       (quo),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: tb/screen_line_clipper_test.sv
// Testbench for screen_line_clipper: drives segments with random idling and stalls,
// predicts each clipped result and checks it in order. Depends on rtl/scl_pkg.sv
// and the screen_line_clipper module.
`default_nettype none
module screen_line_clipper_test;
  import scl_pkg::*;

  localparam int LATENCY = 26;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  scl_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  scl_out_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  int errors = 0;
  int cycles = 0;
  int no_idle = 0;

  screen_line_clipper dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  class clip_scoreboard;
    scl_out_t pending[$];
    longint width_px = 640;
    longint height_px = 360;

    // one boundary test; returns 0 when the segment is rejected
    function automatic bit boundary(input longint p, input longint q,
                                    inout longint te, inout longint tx);
      longint r;
      if (p == 0) return q >= 0;
      r = (q * 65536) / p;
      if (p < 0) begin
        if (r > tx) return 0;
        if (r > te) te = r;
      end else begin
        if (r < te) return 0;
        if (r < tx) tx = r;
      end
      return 1;
    endfunction

    function void note_segment(input scl_in_t s);
      longint sx, sy, ex, ey, da, db, margin, maxx, maxy, dx, dy, te, tx;
      longint ax, ay, bx, by;
      bit ok;
      scl_out_t r;
      r = '0;
      sx = longint'(s.start_x); sy = longint'(s.start_y);
      ex = longint'(s.end_x); ey = longint'(s.end_y);
      da = s.start_depth; db = s.end_depth;
      margin = (3 * longint'(s.line_thickness) * 256) / 4 + 256;
      if (margin < 512) margin = 512;
      maxx = width_px * 256 + margin;
      maxy = height_px * 256 + margin;
      dx = ex - sx; dy = ey - sy;
      te = 0; tx = 65536;
      ok = boundary(-dx, sx + margin, te, tx) && boundary(dx, maxx - sx, te, tx)
        && boundary(-dy, sy + margin, te, tx) && boundary(dy, maxy - sy, te, tx)
        && !(tx < te);
      if (ok) begin
        ax = sx + (dx * te) / 65536; ay = sy + (dy * te) / 65536;
        bx = sx + (dx * tx) / 65536; by = sy + (dy * tx) / 65536;
        if (ax != bx || ay != by) begin
          r.visible = 1'b1;
          r.clip_start_x = ax[23:0]; r.clip_start_y = ay[23:0];
          r.clip_end_x = bx[23:0]; r.clip_end_y = by[23:0];
          r.clip_start_depth = 16'(da + ((db - da) * te) / 65536);
          r.clip_end_depth = 16'(da + ((db - da) * tx) / 65536);
          r.t_entry = te[16:0]; r.t_exit = tx[16:0];
        end
      end
      pending = {pending, r};
    endfunction

    task check_result(input scl_out_t got);
      scl_out_t w;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      w = pending.pop_front();
      if (got.visible !== w.visible) report_mismatch("visible");
      if (got.clip_start_x !== w.clip_start_x) report_mismatch("clip_start_x");
      if (got.clip_start_y !== w.clip_start_y) report_mismatch("clip_start_y");
      if (got.clip_end_x !== w.clip_end_x) report_mismatch("clip_end_x");
      if (got.clip_end_y !== w.clip_end_y) report_mismatch("clip_end_y");
      if (got.clip_start_depth !== w.clip_start_depth) report_mismatch("clip_start_depth");
      if (got.clip_end_depth !== w.clip_end_depth) report_mismatch("clip_end_depth");
      if (got.t_entry !== w.t_entry) report_mismatch("t_entry");
      if (got.t_exit !== w.t_exit) report_mismatch("t_exit");
    endtask
  endclass

  clip_scoreboard board = new();

  // sample results and watch the cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (no_idle > 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 30);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= CFG_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) board.width_px = value;
    else if (idx == REG_SCREEN_HEIGHT) board.height_px = value;
  endtask

  // drop valid and wait until every expected word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // present one word at a falling edge and hold it until accepted
  task automatic send_word(input scl_in_t s);
    while (no_idle == 0 && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    board.note_segment(s);
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord(input int w, input int h);
    int k;
    k = $urandom_range(9);
    if (k < 6) return 24'($signed($urandom_range((w + 20) * 256)) - 10 * 256 -
                          ($urandom_range(1) ? 0 : $urandom_range(w * 128)));
    else if (k < 8) return 24'($signed($urandom_range((h + w) * 512)) - (h + w) * 256);
    else return 24'($urandom);
  endfunction

  function automatic scl_in_t rand_segment(input int w, input int h);
    scl_in_t s;
    s.start_x = rand_coord(w, h); s.start_y = rand_coord(h, w);
    s.end_x = rand_coord(w, h); s.end_y = rand_coord(h, w);
    if ($urandom_range(9) == 0) s.end_x = s.start_x;
    if ($urandom_range(9) == 0) s.end_y = s.start_y;
    s.start_depth = 16'($urandom); s.end_depth = 16'($urandom);
    s.line_thickness = 8'($urandom_range(255));
    return s;
  endfunction

  function automatic scl_in_t seg(input int sx, input int sy, input int ex, input int ey,
                                  input int da, input int db, input int th);
    scl_in_t s;
    s.start_x = 24'(sx); s.start_y = 24'(sy); s.end_x = 24'(ex); s.end_y = 24'(ey);
    s.start_depth = 16'(da); s.end_depth = 16'(db); s.line_thickness = 8'(th);
    return s;
  endfunction

  int widths[5] = '{640, 1, 4096, 0, 8191};
  int heights[5] = '{360, 4096, 1, 0, 8191};

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, axis-parallel lines, inside/outside, empty and point segments
    send_word(seg(-8388608, -8388608, 8388607, 8388607, 0, 65535, 1));
    send_word(seg(8388607, 8388607, -8388608, -8388608, 65535, 0, 255));
    send_word(seg(100*256, 100*256, 200*256, 150*256, 1000, 60000, 0));
    send_word(seg(100*256, -5000, 100*256, 500*256, 0, 65535, 3));
    send_word(seg(-5000, 50*256, -5000, 300*256, 123, 456, 2));
    send_word(seg(-2000*256, 50*256, 2000*256, 50*256, 65535, 0, 128));
    send_word(seg(10*256, 10*256, 10*256, 10*256, 5, 5, 4));
    send_word(seg(10*256, 10*256, 10*256 + 1, 10*256, 5, 9, 4));
    send_word(seg(-8388608, 0, -8388608, 8388607, 0, 0, 0));
    send_word(seg(-100*256, 600*256, 900*256, -300*256, 777, 32768, 200));
    send_word(seg(700*256, 0, 900*256, 100*256, 1, 2, 1));
    send_word(seg(0, 0, 0, 0, 65535, 65535, 255));
    send_word(seg(-600, -600, 700*256, 400*256, 40000, 20, 1));
    drain();
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_SCREEN_WIDTH, widths[p]);
      write_reg(REG_SCREEN_HEIGHT, heights[p]);
      write_reg(REG_UNUSED, $urandom);
      for (int i = 0; i < 280; i++) begin
        if (p == 1 && i == 100) no_idle = 150;
        if (no_idle > 0) no_idle--;
        if (i == 200) drain();
        send_word(rand_segment(widths[p] % 4097, heights[p] % 4097));
      end
      drain();
    end
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
